/* sv/fre_pkg.sv */
// Shared types and constants for the fragment reassembly engine.
// Used by the front classifier, the command queue, the back end and the top level.
package fre_pkg;

  localparam int FRAG_BYTES_DEF = 32;
  localparam int BUF_BYTES_DEF  = 1024;
  localparam int MAX_FRAGS_DEF  = 32;

  localparam int MAP_W       = 64;
  localparam int ADDR_W_MAX  = 12;
  localparam int WIDE_W      = 13;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1024;

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_TICK = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } fre_op_t;

  typedef enum logic [2:0] {
    KIND_STORED   = 3'd0,
    KIND_COMPLETE = 3'd1,
    KIND_DISCARD  = 3'd2,
    KIND_TIMEOUT  = 3'd3,
    KIND_READ     = 3'd4
  } fre_kind_t;

  typedef struct packed {
    fre_op_t                 op;
    logic [15:0]             sender;
    logic [7:0]              pkt_tag;
    logic [10:0]             total_len;
    logic [7:0]              payload_byte;
    logic                    byte_zero;
    logic                    frag_zero;
    logic                    in_range;
    logic                    map_ok;
    logic                    last;
    logic                    wr_en;
    logic                    rd_ok;
    logic                    too_many;
    logic [ADDR_W_MAX-1:0]   addr;
    logic [MAP_W-1:0]        frag_bit;
    logic [MAP_W-1:0]        need;
  } fre_cmd_t;

endpackage

/* sv/fre_front.sv */
// Front classifier of the fragment reassembly engine.
// Decodes one input transaction into a command for the back end; uses fre_pkg.
module fre_front #(
  parameter int FRAG_BYTES = fre_pkg::FRAG_BYTES_DEF,
  parameter int BUF_BYTES  = fre_pkg::BUF_BYTES_DEF,
  parameter int MAX_FRAGS  = fre_pkg::MAX_FRAGS_DEF
) (
  input  logic [1:0]       in_op,
  input  logic [15:0]      in_sender,
  input  logic [7:0]       in_pkt_tag,
  input  logic [4:0]       in_frag_num,
  input  logic [10:0]      in_total_len,
  input  logic [4:0]       in_byte_index,
  input  logic [7:0]       in_payload_byte,
  input  logic             in_last_of_fragment,
  input  logic [9:0]       in_read_addr,
  output fre_pkg::fre_cmd_t cmd_o
);
  import fre_pkg::*;

  logic [WIDE_W-1:0] base;
  logic [WIDE_W-1:0] waddr;
  logic [WIDE_W-1:0] raddr;

  always_comb begin
    base  = WIDE_W'(in_frag_num) * WIDE_W'(FRAG_BYTES);
    waddr = base + WIDE_W'(in_byte_index);
    raddr = WIDE_W'(in_read_addr);

    cmd_o              = '0;
    cmd_o.op           = fre_op_t'(in_op);
    cmd_o.sender       = in_sender;
    cmd_o.pkt_tag      = in_pkt_tag;
    cmd_o.total_len    = in_total_len;
    cmd_o.payload_byte = in_payload_byte;
    cmd_o.byte_zero    = (in_byte_index == 5'd0);
    cmd_o.frag_zero    = (in_frag_num == 5'd0);
    cmd_o.map_ok       = 32'(in_frag_num) < MAX_FRAGS;
    cmd_o.in_range     = cmd_o.map_ok && (32'(base) < BUF_BYTES);
    cmd_o.last         = in_last_of_fragment;
    cmd_o.wr_en        = (32'(in_byte_index) < FRAG_BYTES) && (32'(waddr) < BUF_BYTES);
    cmd_o.rd_ok        = 32'(raddr) < BUF_BYTES;
    cmd_o.too_many     = 32'(in_total_len) > MAX_FRAGS * FRAG_BYTES;
    cmd_o.addr         = (cmd_o.op == OP_READ) ? raddr[ADDR_W_MAX-1:0]
                                               : waddr[ADDR_W_MAX-1:0];
    for (int i = 0; i < MAX_FRAGS; i++) begin
      cmd_o.frag_bit[i] = (32'(in_frag_num) == i);
      cmd_o.need[i]     = 32'(in_total_len) > i * FRAG_BYTES;
    end
  end

endmodule

/* sv/fre_queue.sv */
// Short command queue between the front classifier and the back end.
// Holds fre_pkg::fre_cmd_t entries so that each side can stall on its own.
module fre_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  fre_pkg::fre_cmd_t in_cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output fre_pkg::fre_cmd_t out_cmd
);
  import fre_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  fre_cmd_t         ent_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push, pop;

  assign in_ready  = (cnt_r != CNT_W'(QUEUE_DEPTH));
  assign out_valid = (cnt_r != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_cmd   = ent_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= in_cmd;
    end
  end

endmodule

/* sv/fre_back.sv */
// Back end of the fragment reassembly engine: reassembly state, buffer and result register.
// Executes one command from fre_queue per cycle unless a held result stalls it; uses fre_pkg.
module fre_back #(
  parameter int BUF_BYTES = fre_pkg::BUF_BYTES_DEF,
  parameter int MAX_FRAGS = fre_pkg::MAX_FRAGS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  fre_pkg::fre_cmd_t cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_kind,
  output logic [7:0]        out_read_data,
  output logic [10:0]       out_packet_len,
  output logic [15:0]       out_from_sender,
  output logic [7:0]        out_current_id
);
  import fre_pkg::*;

  localparam int ADDR_W = $clog2(BUF_BYTES);

  logic [7:0]           mem [BUF_BYTES];
  logic [7:0]           rd_data_r;

  logic [15:0]          timeout_r;
  logic                 recv_r, recv_nxt;
  logic [15:0]          sender_r, sender_nxt;
  logic [7:0]           id_r, id_nxt;
  logic [10:0]          len_r, len_nxt;
  logic [MAX_FRAGS-1:0] map_r, map_nxt, map_w, need;
  logic [15:0]          cnt_r, cnt_nxt, cnt_inc;
  logic                 run_r, run_nxt;
  logic                 fok_r, fok_nxt, new_ok;

  logic                 out_valid_r;
  fre_kind_t            out_kind_r;
  logic                 out_rd_sel_r;
  logic [10:0]          out_len_r;
  logic [15:0]          out_sender_r;
  logic [7:0]           out_id_r;

  fre_kind_t            kind;
  logic                 emit;
  logic                 mem_we, mem_re;
  logic                 fire;

  assign cmd_ready = !out_valid_r || out_ready;
  assign fire      = cmd_valid && cmd_ready;
  assign need      = cmd.need[MAX_FRAGS-1:0];

  always_comb begin
    recv_nxt   = recv_r;
    sender_nxt = sender_r;
    id_nxt     = id_r;
    len_nxt    = len_r;
    map_nxt    = map_r;
    map_w      = map_r;
    cnt_nxt    = cnt_r;
    cnt_inc    = cnt_r;
    run_nxt    = run_r;
    fok_nxt    = fok_r;
    new_ok     = fok_r;
    kind       = KIND_STORED;
    emit       = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    unique case (cmd.op)
      OP_BYTE: begin
        if (cmd.byte_zero) begin
          new_ok  = cmd.in_range &&
                    (!recv_r || (cmd.sender == sender_r && cmd.pkt_tag == id_r));
          fok_nxt = new_ok;
          if (new_ok) begin
            recv_nxt = 1'b1;
            if (cmd.frag_zero) begin
              sender_nxt = cmd.sender;
              id_nxt     = cmd.pkt_tag;
              len_nxt    = cmd.total_len;
              map_w      = '0;
            end
            cnt_nxt = '0;
            run_nxt = 1'b1;
          end
        end
        emit = 1'b1;
        if (!new_ok) begin
          kind = KIND_DISCARD;
        end else begin
          mem_we = cmd.wr_en;
          if (cmd.last && cmd.map_ok) begin
            map_w = map_w | cmd.frag_bit[MAX_FRAGS-1:0];
            if (!cmd.too_many && ((map_w & need) == need)) begin
              run_nxt  = 1'b0;
              recv_nxt = 1'b0;
              kind     = KIND_COMPLETE;
            end
          end
        end
        map_nxt = map_w;
      end
      OP_TICK: begin
        if (run_r) begin
          cnt_inc = (cnt_r != 16'hFFFF) ? cnt_r + 16'd1 : cnt_r;
          cnt_nxt = cnt_inc;
          if (cnt_inc >= timeout_r) begin
            len_nxt    = '0;
            sender_nxt = '0;
            map_nxt    = '0;
            recv_nxt   = 1'b0;
            run_nxt    = 1'b0;
            cnt_nxt    = '0;
            fok_nxt    = 1'b0;
            kind       = KIND_TIMEOUT;
            emit       = 1'b1;
          end
        end
      end
      OP_READ: begin
        kind   = KIND_READ;
        emit   = 1'b1;
        mem_re = 1'b1;
      end
      OP_NONE: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= TIMEOUT_RESET;
      recv_r      <= 1'b0;
      sender_r    <= '0;
      id_r        <= '0;
      len_r       <= '0;
      map_r       <= '0;
      cnt_r       <= '0;
      run_r       <= 1'b0;
      fok_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        timeout_r <= cfg_wdata;
      end
      if (fire) begin
        recv_r   <= recv_nxt;
        sender_r <= sender_nxt;
        id_r     <= id_nxt;
        len_r    <= len_nxt;
        map_r    <= map_nxt;
        cnt_r    <= cnt_nxt;
        run_r    <= run_nxt;
        fok_r    <= fok_nxt;
      end
      if (fire) begin
        out_valid_r <= emit;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_kind_r   <= kind;
      out_rd_sel_r <= mem_re && cmd.rd_ok;
      out_len_r    <= len_nxt;
      out_sender_r <= sender_nxt;
      out_id_r     <= id_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && mem_we) begin
      mem[cmd.addr[ADDR_W-1:0]] <= cmd.payload_byte;
    end
    if (fire && mem_re) begin
      rd_data_r <= mem[cmd.addr[ADDR_W-1:0]];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_read_data   = out_rd_sel_r ? rd_data_r : 8'd0;
  assign out_packet_len  = out_len_r;
  assign out_from_sender = out_sender_r;
  assign out_current_id  = out_id_r;

  a_run_matches_recv: assert property (@(posedge clk) disable iff (!rst_n)
    run_r == recv_r)
    else $error("Timer state and receiving state disagree.");

  a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire && cmd.op == OP_READ |=> out_valid_r && out_kind_r == KIND_READ)
    else $error("A buffer read did not produce a read result.");

  a_timeout_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && emit && kind == KIND_TIMEOUT |=> map_r == '0 && !fok_r && !run_r)
    else $error("A timeout left reassembly state behind.");

endmodule

/* sv/fragment_reassembly_engine.sv */
// Top level of the fragment reassembly engine.
// Instantiates fre_front, fre_queue and fre_back; uses fre_pkg.
//
// The engine takes one input transaction per clock cycle while the queue has room and
// gives at most one result transaction per cycle: payload bytes, timer ticks and buffer
// reads all pass at that rate. A result appears in the cycle after its transaction leaves
// the two-entry command queue, because the reassembly buffer is a single-port memory with a
// registered read. The buffer has no clearing pass, so the engine is ready right after
// reset. The timeout register may be written at any time the engine is idle.
module fragment_reassembly_engine #(
  parameter int FRAG_BYTES = fre_pkg::FRAG_BYTES_DEF,
  parameter int BUF_BYTES  = fre_pkg::BUF_BYTES_DEF,
  parameter int MAX_FRAGS  = fre_pkg::MAX_FRAGS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_sender,
  input  logic [7:0]  in_pkt_tag,
  input  logic [4:0]  in_frag_num,
  input  logic [10:0] in_total_len,
  input  logic [4:0]  in_byte_index,
  input  logic [7:0]  in_payload_byte,
  input  logic        in_last_of_fragment,
  input  logic [9:0]  in_read_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_read_data,
  output logic [10:0] out_packet_len,
  output logic [15:0] out_from_sender,
  output logic [7:0]  out_current_id,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import fre_pkg::*;

  fre_cmd_t front_cmd;
  fre_cmd_t back_cmd;
  logic     back_valid;
  logic     back_ready;

  fre_front #(
    .FRAG_BYTES (FRAG_BYTES),
    .BUF_BYTES  (BUF_BYTES),
    .MAX_FRAGS  (MAX_FRAGS)
  ) u_front (
    .in_op               (in_op),
    .in_sender           (in_sender),
    .in_pkt_tag          (in_pkt_tag),
    .in_frag_num         (in_frag_num),
    .in_total_len        (in_total_len),
    .in_byte_index       (in_byte_index),
    .in_payload_byte     (in_payload_byte),
    .in_last_of_fragment (in_last_of_fragment),
    .in_read_addr        (in_read_addr),
    .cmd_o               (front_cmd)
  );

  fre_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (front_cmd),
    .out_valid (back_valid),
    .out_ready (back_ready),
    .out_cmd   (back_cmd)
  );

  fre_back #(
    .BUF_BYTES (BUF_BYTES),
    .MAX_FRAGS (MAX_FRAGS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .cmd_valid       (back_valid),
    .cmd_ready       (back_ready),
    .cmd             (back_cmd),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_read_data   (out_read_data),
    .out_packet_len  (out_packet_len),
    .out_from_sender (out_from_sender),
    .out_current_id  (out_current_id)
  );

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for fragment_reassembly_engine, written against fre_pkg.
// A behavioral model of the reassembly state predicts every result transaction, and
// the results are compared in order while both channels stall at random.
module tb_top;
  import fre_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    fre_op_t     op;
    logic [15:0] sender;
    logic [7:0]  pkt_tag;
    logic [4:0]  frag_num;
    logic [10:0] total_len;
    logic [4:0]  byte_index;
    logic [7:0]  payload;
    logic        last;
    logic [9:0]  read_addr;
  } frag_item_t;

  typedef struct {
    fre_kind_t   kind;
    logic [7:0]  read_data;
    logic [10:0] packet_len;
    logic [15:0] from_sender;
    logic [7:0]  current_id;
  } engine_event_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_op;
  logic [15:0] in_sender;
  logic [7:0]  in_pkt_tag;
  logic [4:0]  in_frag_num;
  logic [10:0] in_total_len;
  logic [4:0]  in_byte_index;
  logic [7:0]  in_payload_byte;
  logic        in_last_of_fragment;
  logic [9:0]  in_read_addr;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_kind;
  logic [7:0]  out_read_data;
  logic [10:0] out_packet_len;
  logic [15:0] out_from_sender;
  logic [7:0]  out_current_id;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  logic                      m_receiving = 1'b0;
  logic [15:0]               m_sender = '0;
  logic [7:0]                m_id = '0;
  logic [10:0]               m_len = '0;
  logic [MAX_FRAGS_DEF-1:0]  m_map = '0;
  logic [15:0]               m_count = '0;
  logic                      m_timer_on = 1'b0;
  logic                      m_frag_ok = 1'b0;
  logic [15:0]               m_timeout = TIMEOUT_RESET;
  logic [7:0]                m_buf [BUF_BYTES_DEF];
  bit                        m_written [BUF_BYTES_DEF];
  int                        written_addrs [$];

  engine_event_t expected_events [$];
  engine_event_t want;
  int            mismatch_count = 0;
  int            items_sent = 0;
  int            cycle_count = 0;
  int            out_wait = 0;
  bit            idle_free = 1'b0;

  fragment_reassembly_engine i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_op               (in_op),
    .in_sender           (in_sender),
    .in_pkt_tag          (in_pkt_tag),
    .in_frag_num         (in_frag_num),
    .in_total_len        (in_total_len),
    .in_byte_index       (in_byte_index),
    .in_payload_byte     (in_payload_byte),
    .in_last_of_fragment (in_last_of_fragment),
    .in_read_addr        (in_read_addr),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_kind            (out_kind),
    .out_read_data       (out_read_data),
    .out_packet_len      (out_packet_len),
    .out_from_sender     (out_from_sender),
    .out_current_id      (out_current_id),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] exp_val);
    mismatch_count++;
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got,
             exp_val);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_events.size() == 0) begin
        report_mismatch("result with nothing expected, kind", 16'(out_kind), 16'd0);
      end else begin
        want = expected_events.pop_front();
        if (out_kind !== want.kind)
          report_mismatch("kind", 16'(out_kind), 16'(want.kind));
        if (out_read_data !== want.read_data)
          report_mismatch("read_data", 16'(out_read_data), 16'(want.read_data));
        if (out_packet_len !== want.packet_len)
          report_mismatch("packet_len", 16'(out_packet_len), 16'(want.packet_len));
        if (out_from_sender !== want.from_sender)
          report_mismatch("from_sender", out_from_sender, want.from_sender);
        if (out_current_id !== want.current_id)
          report_mismatch("current_id", 16'(out_current_id), 16'(want.current_id));
      end
      out_wait = idle_free ? 0 : $urandom_range(0, 8);
      if (out_wait != 0) out_ready <= 1'b0;
    end else if (!out_ready) begin
      if (out_wait <= 1) out_ready <= 1'b1;
      out_wait--;
    end
  end

  task automatic push_event(input fre_kind_t kind, input logic [7:0] data);
    engine_event_t ev;
    ev.kind        = kind;
    ev.read_data   = data;
    ev.packet_len  = m_len;
    ev.from_sender = m_sender;
    ev.current_id  = m_id;
    expected_events.push_back(ev);
  endtask

  function automatic bit packet_complete(input logic [10:0] len);
    int  n;
    bit  all_set;
    n = (int'(len) + FRAG_BYTES_DEF - 1) / FRAG_BYTES_DEF;
    all_set = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (i >= MAX_FRAGS_DEF || !m_map[i]) all_set = 1'b0;
    end
    return all_set;
  endfunction

  task automatic predict_reassembly(input frag_item_t it);
    int   base;
    int   addr;
    bit   accept;
    bit   done;
    case (it.op)
      OP_BYTE: begin
        base = int'(it.frag_num) * FRAG_BYTES_DEF;
        addr = base + int'(it.byte_index);
        if (it.byte_index == 5'd0) begin
          accept = (int'(it.frag_num) < MAX_FRAGS_DEF) && (base < BUF_BYTES_DEF) &&
                   (!m_receiving || (it.sender == m_sender && it.pkt_tag == m_id));
          m_frag_ok = accept;
          if (accept) begin
            m_receiving = 1'b1;
            if (it.frag_num == 5'd0) begin
              m_sender = it.sender;
              m_id     = it.pkt_tag;
              m_len    = it.total_len;
              m_map    = '0;
            end
            m_count    = '0;
            m_timer_on = 1'b1;
          end
        end
        if (!m_frag_ok) begin
          push_event(KIND_DISCARD, 8'd0);
        end else begin
          done = 1'b0;
          if (int'(it.byte_index) < FRAG_BYTES_DEF && addr < BUF_BYTES_DEF) begin
            m_buf[addr] = it.payload;
            if (!m_written[addr]) begin
              m_written[addr] = 1'b1;
              written_addrs.push_back(addr);
            end
          end
          if (it.last && int'(it.frag_num) < MAX_FRAGS_DEF) begin
            m_map[it.frag_num] = 1'b1;
            if (packet_complete(it.total_len)) begin
              m_timer_on  = 1'b0;
              m_receiving = 1'b0;
              push_event(KIND_COMPLETE, 8'd0);
              done = 1'b1;
            end
          end
          if (!done) push_event(KIND_STORED, 8'd0);
        end
      end
      OP_TICK: begin
        if (m_timer_on) begin
          if (m_count != 16'hFFFF) m_count++;
          if (m_count >= m_timeout) begin
            m_len       = '0;
            m_sender    = '0;
            m_map       = '0;
            m_receiving = 1'b0;
            m_timer_on  = 1'b0;
            m_count     = '0;
            m_frag_ok   = 1'b0;
            push_event(KIND_TIMEOUT, 8'd0);
          end
        end
      end
      OP_READ: begin
        if (int'(it.read_addr) < BUF_BYTES_DEF) push_event(KIND_READ, m_buf[it.read_addr]);
        else push_event(KIND_READ, 8'd0);
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_item(input frag_item_t it);
    int gap;
    gap = idle_free ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_op               <= it.op;
    in_sender           <= it.sender;
    in_pkt_tag          <= it.pkt_tag;
    in_frag_num         <= it.frag_num;
    in_total_len        <= it.total_len;
    in_byte_index       <= it.byte_index;
    in_payload_byte     <= it.payload;
    in_last_of_fragment <= it.last;
    in_read_addr        <= it.read_addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_reassembly(it);
    if (it.op != OP_NONE) items_sent++;
  endtask

  task automatic send_byte(input logic [15:0] snd, input logic [7:0] pid, input int fnr,
                           input logic [10:0] tlen, input int bidx, input logic [7:0] data,
                           input bit last);
    frag_item_t it;
    it = '{OP_BYTE, snd, pid, 5'(fnr), tlen, 5'(bidx), data, last, 10'd0};
    send_item(it);
  endtask

  task automatic send_ticks(input int n);
    frag_item_t it;
    it = '{OP_TICK, 16'd0, 8'd0, 5'd0, 11'd0, 5'd0, 8'd0, 1'b0, 10'd0};
    repeat (n) send_item(it);
  endtask

  task automatic send_read(input logic [9:0] addr);
    frag_item_t it;
    it = '{OP_READ, 16'd0, 8'd0, 5'd0, 11'd0, 5'd0, 8'd0, 1'b0, addr};
    send_item(it);
  endtask

  function automatic logic [9:0] pick_written();
    return 10'(written_addrs[$urandom_range(0, written_addrs.size() - 1)]);
  endfunction

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] ticks);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= ticks;
    @(posedge clk);
    cfg_we    <= 1'b0;
    m_timeout = ticks;
  endtask

  task automatic test_directed_cases();
    frag_item_t it;
    idle_free = 1'b0;
    send_byte(16'h0001, 8'h01, 0, 11'd10, 5, 8'h33, 1'b1);
    it = '{OP_NONE, 16'hFFFF, 8'hFF, 5'd31, 11'h7FF, 5'd31, 8'hFF, 1'b1, 10'h3FF};
    send_item(it);
    send_ticks(1);
    send_byte(16'hFFFF, 8'hFF, 0, 11'd0, 0, 8'hFF, 1'b1);
    send_read(10'd0);
    send_byte(16'h0000, 8'h00, 31, 11'h7FF, 0, 8'h00, 1'b0);
    send_byte(16'h0000, 8'h00, 31, 11'h7FF, 31, 8'hA5, 1'b1);
    send_read(10'h3FF);
    send_byte(16'h1234, 8'hFF, 0, 11'd40, 0, 8'h01, 1'b0);
    send_byte(16'hFFFF, 8'h00, 0, 11'd40, 0, 8'h02, 1'b0);
    send_byte(16'hFFFF, 8'hFF, 0, 11'd40, 1, 8'h03, 1'b0);
    send_byte(16'hFFFF, 8'hFF, 0, 11'd33, 0, 8'h5A, 1'b0);
    send_byte(16'hFFFF, 8'hFF, 0, 11'd33, 1, 8'hC3, 1'b1);
    send_byte(16'hFFFF, 8'hFF, 1, 11'd33, 0, 8'h3C, 1'b1);
    send_read(10'd1);
    send_read(10'd32);
    send_read(10'd992);
  endtask

  task automatic test_timeout_drop();
    write_timeout(16'd1);
    send_byte(16'h0042, 8'h10, 0, 11'd100, 0, 8'h11, 1'b0);
    send_ticks(2);
    send_byte(16'h0042, 8'h10, 0, 11'd100, 1, 8'h12, 1'b0);
    write_timeout(16'd0);
    send_byte(16'h8000, 8'h80, 0, 11'd1024, 0, 8'h21, 1'b1);
    send_ticks(1);
    write_timeout(16'd5);
    send_byte(16'h0777, 8'h55, 0, 11'd70, 0, 8'h31, 1'b1);
    send_ticks(4);
    send_byte(16'h0777, 8'h55, 2, 11'd70, 0, 8'h32, 1'b1);
    send_ticks(4);
    send_byte(16'h0777, 8'h55, 2, 11'd70, 1, 8'h33, 1'b0);
    send_ticks(2);
  endtask

  task automatic test_random_traffic();
    int          phase_ticks [6] = '{3, 65535, 1, 0, 12, 40};
    int          phase_start;
    int          sel;
    int          nfrag;
    int          k;
    int          swap_idx;
    int          tmp;
    int          order [$];
    logic [15:0] snd;
    logic [7:0]  pid;
    logic [10:0] tlen;
    frag_item_t  it;
    foreach (phase_ticks[ph]) begin
      write_timeout(16'(phase_ticks[ph]));
      idle_free = ($urandom_range(0, 3) == 0);
      phase_start = items_sent;
      while (items_sent - phase_start < 255) begin
        if ($urandom_range(0, 15) == 0) idle_free = !idle_free;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
          it.op         = fre_op_t'($urandom_range(0, 3));
          it.sender     = 16'($urandom);
          it.pkt_tag    = 8'($urandom);
          it.frag_num   = 5'($urandom);
          it.total_len  = 11'($urandom);
          it.byte_index = 5'($urandom);
          it.payload    = 8'($urandom);
          it.last       = 1'($urandom);
          it.read_addr  = 10'($urandom);
          if (it.op == OP_READ) begin
            if (written_addrs.size() == 0) it.op = OP_TICK;
            else it.read_addr = pick_written();
          end
          send_item(it);
        end else if (sel == 1) begin
          send_ticks($urandom_range(1, 6));
        end else begin
          if (m_receiving && $urandom_range(0, 3) != 0) begin
            snd = m_sender;
            pid = m_id;
          end else begin
            snd = 16'($urandom);
            pid = 8'($urandom);
          end
          sel = $urandom_range(0, 19);
          if (sel == 0) tlen = 11'd0;
          else if (sel == 1) tlen = 11'($urandom_range(1025, 2047));
          else if (sel == 2) tlen = 11'd1024;
          else tlen = 11'($urandom_range(1, 160));
          nfrag = (tlen == 0) ? 1 : (int'(tlen) + FRAG_BYTES_DEF - 1) / FRAG_BYTES_DEF;
          if (nfrag > MAX_FRAGS_DEF) nfrag = MAX_FRAGS_DEF;
          order = {};
          for (int f = 0; f < nfrag; f++) order.push_back(f);
          while (order.size() > 5 && tlen != 11'd1024) void'(order.pop_back());
          if ($urandom_range(0, 3) == 0) begin
            swap_idx = $urandom_range(0, order.size() - 1);
            tmp = order[0];
            order[0] = order[swap_idx];
            order[swap_idx] = tmp;
          end
          if ($urandom_range(0, 7) == 0 && order.size() > 1) void'(order.pop_back());
          foreach (order[i]) begin
            if (nfrag > 6) k = 1;
            else if ($urandom_range(0, 7) == 0) k = FRAG_BYTES_DEF;
            else k = $urandom_range(1, 4);
            for (int j = 0; j < k; j++)
              send_byte(snd, pid, order[i], tlen, j, 8'($urandom), j == k - 1);
            if ($urandom_range(0, 3) == 0) send_ticks($urandom_range(1, 3));
          end
          if ($urandom_range(0, 2) == 0 && written_addrs.size() != 0) begin
            repeat ($urandom_range(1, 3)) send_read(pick_written());
          end
        end
      end
    end
  endtask

  initial begin
    rst_n               <= 1'b0;
    in_valid            <= 1'b0;
    in_op               <= OP_NONE;
    in_sender           <= '0;
    in_pkt_tag          <= '0;
    in_frag_num         <= '0;
    in_total_len        <= '0;
    in_byte_index       <= '0;
    in_payload_byte     <= '0;
    in_last_of_fragment <= 1'b0;
    in_read_addr        <= '0;
    out_ready           <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_timeout_drop();
    test_random_traffic();
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_events.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/fre_pkg.sv
sv/fre_front.sv
sv/fre_queue.sv
sv/fre_back.sv
sv/fragment_reassembly_engine.sv
tb/tb_top.sv
